### design/pgb_pkg.sv
package pgb_pkg;

  // Default sizes
  localparam int DEF_MAX_VARS   = 256;
  localparam int DEF_MAX_CHECKS = 128;
  localparam int DEF_MAX_DEGREE = 8;

  // Payload field widths
  localparam int VAR_IDX_W  = 8;
  localparam int EDGE_CNT_W = 4;
  localparam int CHK_IDX_W  = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Configuration registers
  localparam int CHECKS_REG_W = 8;
  localparam int VARS_REG_W   = 9;
  localparam logic [CHECKS_REG_W-1:0] CHECKS_RESET = 8'd102;
  localparam logic [VARS_REG_W-1:0]   VARS_RESET   = 9'd204;
  localparam logic REG_CHECKS = 1'b0;
  localparam logic REG_VARS   = 1'b1;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Degree counters and adjacency words
  localparam int DEG_W = 9;
  localparam logic [DEG_W-1:0] DEG_SAT = 9'd511;
  localparam int WORD_W = 64;

endpackage

### design/pgb_ram.sv
module pgb_ram import pgb_pkg::*; #(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pgb_core.sv
module pgb_core import pgb_pkg::*; #(
  parameter int MAX_VARS   = DEF_MAX_VARS,
  parameter int MAX_CHECKS = DEF_MAX_CHECKS,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_CHECKS+1)-1:0]   nc,
  input  logic [$clog2(MAX_VARS+1)-1:0]     nv,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_DATA_W-1:0]              s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_DATA_W-1:0]             m_tdata,
  output logic                              m_tlast
);

  localparam int VWORDS    = (MAX_VARS + 63) / 64;
  localparam int VBITS     = VWORDS * WORD_W;
  localparam int C_W       = $clog2(MAX_CHECKS);
  localparam int V_W       = $clog2(MAX_VARS);
  localparam int W_W       = (VWORDS > 1) ? $clog2(VWORDS) : 1;
  localparam int CN_W      = $clog2(MAX_CHECKS + 1);
  localparam int ADJ_DEPTH = MAX_CHECKS * VWORDS;
  localparam int ADJ_AW    = $clog2(ADJ_DEPTH);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_PICK   = 7'b0000100,
    ST_RMW_RD = 7'b0001000,
    ST_RMW_WR = 7'b0010000,
    ST_WALK   = 7'b0100000,
    ST_ROUND  = 7'b1000000
  } state_t;

  state_t                state;
  logic [ADJ_AW-1:0]     clr_addr;
  logic [V_W-1:0]        v;
  logic [EDGE_CNT_W-1:0] n_edges;
  logic [EDGE_CNT_W-1:0] k;
  logic [CN_W-1:0]       ic;
  logic [W_W-1:0]        iw;
  logic [ADJ_AW-1:0]     ra;
  logic                  d_valid;
  logic [C_W-1:0]        d_c;
  logic [W_W-1:0]        d_w;
  logic                  d_lastrow;
  logic [C_W-1:0]        best;
  logic [DEG_W:0]        best_deg;
  logic [VBITS-1:0]      visited;
  logic [VBITS-1:0]      var_old;
  logic [VBITS-1:0]      var_new;
  logic [VBITS-1:0]      row_buf;
  logic [MAX_CHECKS-1:0] reached_prev;
  logic [MAX_CHECKS-1:0] reached_new;
  logic                  out_valid;
  logic [CHK_IDX_W-1:0]  out_chk;
  logic                  out_last;

  logic                  adj_we;
  logic [ADJ_AW-1:0]     adj_waddr;
  logic [WORD_W-1:0]     adj_wdata;
  logic [ADJ_AW-1:0]     adj_raddr;
  logic [WORD_W-1:0]     adj_rdata;
  logic                  deg_we;
  logic [C_W-1:0]        deg_waddr;
  logic [DEG_W-1:0]      deg_wdata;
  logic [DEG_W-1:0]      deg_rdata;

  logic                  issue;
  logic                  last_word;
  logic [ADJ_AW-1:0]     rmw_addr;
  logic [5:0]            vbit;
  logic [VBITS-1:0]      nv_mask;
  logic [MAX_CHECKS-1:0] nc_mask;
  logic [VBITS-1:0]      row_full;
  logic [VBITS-1:0]      row_fresh;
  logic                  row_hit;
  logic                  out_free;
  logic [VBITS-1:0]      v_onehot;
  logic [VAR_IDX_W-1:0]  in_var;
  logic [EDGE_CNT_W-1:0] in_cnt;

  assign in_var   = s_tdata[VAR_IDX_W-1:0];
  assign in_cnt   = s_tdata[VAR_IDX_W +: EDGE_CNT_W];
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-CHK_IDX_W){1'b0}}, out_chk};
  assign m_tlast  = out_last;
  assign out_free = !out_valid || m_tready;

  assign issue     = (ic < nc) && (state == ST_PICK || state == ST_WALK);
  assign last_word = (32'(iw) == VWORDS - 1);
  assign vbit      = 6'(32'(v) & 32'd63);
  assign rmw_addr  = ADJ_AW'(32'(best) * VWORDS + (32'(v) >> 6));
  assign v_onehot  = VBITS'(1) << v;

  always_comb begin
    for (int u = 0; u < VBITS; u++) begin
      nv_mask[u] = (u < 32'(nv));
    end
    for (int c = 0; c < MAX_CHECKS; c++) begin
      nc_mask[c] = (c < 32'(nc));
    end
  end

  always_comb begin
    row_full = row_buf;
    row_full[(VWORDS-1)*WORD_W +: WORD_W] = adj_rdata;
    row_hit   = |(row_full & var_old & nv_mask);
    row_fresh = row_full & ~visited & nv_mask;
  end

  // Memory ports
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = rmw_addr;
    adj_wdata = adj_rdata | (WORD_W'(1) << vbit);
    deg_we    = 1'b0;
    deg_waddr = best;
    deg_wdata = (best_deg[DEG_W-1:0] < DEG_SAT) ? best_deg[DEG_W-1:0] + DEG_W'(1)
                                                : best_deg[DEG_W-1:0];
    adj_raddr = (state == ST_RMW_RD || state == ST_RMW_WR) ? rmw_addr : ra;
    case (state)
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_addr;
        adj_wdata = '0;
        deg_we    = (32'(clr_addr) < MAX_CHECKS);
        deg_waddr = C_W'(clr_addr);
        deg_wdata = '0;
      end
      ST_RMW_WR: begin
        adj_we = out_free;
        deg_we = out_free;
      end
      default: begin
      end
    endcase
  end

  pgb_ram #(.WIDTH(WORD_W), .DEPTH(ADJ_DEPTH)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  pgb_ram #(.WIDTH(DEG_W), .DEPTH(MAX_CHECKS)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (C_W'(ic)),
    .rdata (deg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      d_valid   <= 1'b0;
    end else begin
      if (out_valid && m_tready && state != ST_RMW_WR) begin
        out_valid <= 1'b0;
      end

      // read issue: one row word (walk) or one degree (pick) per cycle
      d_valid <= issue;
      d_c     <= C_W'(ic);
      d_w     <= iw;
      if (issue) begin
        if (state == ST_PICK) begin
          d_lastrow <= (ic == nc - CN_W'(1));
          ic        <= ic + CN_W'(1);
        end else begin
          d_lastrow <= (ic == nc - CN_W'(1)) && last_word;
          ra        <= ra + ADJ_AW'(1);
          if (last_word) begin
            iw <= '0;
            ic <= ic + CN_W'(1);
          end else begin
            iw <= iw + W_W'(1);
          end
        end
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADJ_AW'(1);
          if (32'(clr_addr) == ADJ_DEPTH - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid && 32'(in_var) < 32'(nv) && in_cnt != '0) begin
            v            <= V_W'(in_var);
            n_edges      <= (32'(in_cnt) > MAX_DEGREE) ? EDGE_CNT_W'(MAX_DEGREE) : in_cnt;
            k            <= '0;
            reached_prev <= '0;
            ic           <= '0;
            best         <= '0;
            best_deg     <= '1;
            state        <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (d_valid) begin
            if (!reached_prev[d_c] && {1'b0, deg_rdata} < best_deg) begin
              best     <= d_c;
              best_deg <= {1'b0, deg_rdata};
            end
            if (d_lastrow) begin
              state <= ST_RMW_RD;
            end
          end
        end
        ST_RMW_RD: begin
          state <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          // hold until the output register can take the edge
          if (out_free) begin
            out_valid <= 1'b1;
            out_chk   <= CHK_IDX_W'(best);
            out_last  <= (k + EDGE_CNT_W'(1) == n_edges);
            k         <= k + EDGE_CNT_W'(1);
            if (k + EDGE_CNT_W'(1) == n_edges) begin
              state <= ST_IDLE;
            end else begin
              visited      <= v_onehot;
              var_old      <= v_onehot;
              var_new      <= '0;
              reached_prev <= '0;
              reached_new  <= '0;
              row_buf      <= '0;
              ic           <= '0;
              iw           <= '0;
              ra           <= '0;
              state        <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (d_valid) begin
            if (32'(d_w) != VWORDS - 1) begin
              row_buf[32'(d_w)*WORD_W +: WORD_W] <= adj_rdata;
            end else if (row_hit && !reached_prev[d_c]) begin
              reached_new[d_c] <= 1'b1;
              var_new          <= var_new | row_fresh;
              visited          <= visited | row_fresh;
            end
            if (d_lastrow) begin
              state <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          ic <= '0;
          if (reached_new == nc_mask || reached_new == reached_prev) begin
            best     <= '0;
            best_deg <= '1;
            state    <= ST_PICK;
          end else begin
            reached_prev <= reached_new;
            var_old      <= var_new;
            var_new      <= '0;
            iw           <= '0;
            ra           <= '0;
            state        <= ST_WALK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/peg_tanner_graph_builder_unit.sv
// Progressive edge growth builder for an LDPC Tanner graph. Each input transaction names a
// variable node and its degree; the block returns one check index per edge, tlast on the final
// one. The adjacency bits live in a 64-bit wide memory of MAX_CHECKS * ceil(MAX_VARS/64) words
// and the check degrees in a second memory, both with registered read ports. After reset a
// clearing pass writes zero to every adjacency word and no input is taken meanwhile;
// configuration writes are taken at any time. The first edge of an item comes from a sweep
// with one degree read per check in use. Each later edge runs breadth-first layers, each of
// checks_in_use * ceil(MAX_VARS/64) adjacency reads, followed by another degree sweep;
// the number of layers grows with the graph depth, so the adjacency read port sets the rate.
// Out-of-range variables and zero edge counts are consumed with no result. The next input
// is taken while the last result of an item still waits.
module peg_tanner_graph_builder_unit import pgb_pkg::*; #(
  parameter int MAX_VARS   = DEF_MAX_VARS,
  parameter int MAX_CHECKS = DEF_MAX_CHECKS,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [7:0] var_index, [11:8] edge_count
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [6:0] check_index
  output logic                   m_tlast
);

  localparam int CN_W = $clog2(MAX_CHECKS + 1);
  localparam int VN_W = $clog2(MAX_VARS + 1);

  logic [CHECKS_REG_W-1:0] checks_in_use;
  logic [VARS_REG_W-1:0]   vars_in_use;
  logic [CN_W-1:0]         nc;
  logic [VN_W-1:0]         nv;
  logic                    apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      checks_in_use <= CHECKS_RESET;
      vars_in_use   <= VARS_RESET;
    end else if (apb_wr) begin
      if (paddr[2] == REG_CHECKS) begin
        checks_in_use <= pwdata[CHECKS_REG_W-1:0];
      end else begin
        vars_in_use <= pwdata[VARS_REG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_VARS) ? APB_DATA_W'(vars_in_use) : APB_DATA_W'(checks_in_use);

  // zero counts as one, saturate at the built size
  always_comb begin
    if (checks_in_use == '0) begin
      nc = CN_W'(1);
    end else if (32'(checks_in_use) > MAX_CHECKS) begin
      nc = CN_W'(MAX_CHECKS);
    end else begin
      nc = CN_W'(checks_in_use);
    end
    if (vars_in_use == '0) begin
      nv = VN_W'(1);
    end else if (32'(vars_in_use) > MAX_VARS) begin
      nv = VN_W'(MAX_VARS);
    end else begin
      nv = VN_W'(vars_in_use);
    end
  end

  pgb_core #(
    .MAX_VARS   (MAX_VARS),
    .MAX_CHECKS (MAX_CHECKS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .nc       (nc),
    .nv       (nv),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_clear_blocks_input: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("input taken during clearing pass");

  a_check_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[CHK_IDX_W-1:0]) < 32'(nc)))
    else $error("chosen check beyond check count");

  a_counts_clamped: assert property (@(posedge clk) disable iff (rst)
    (nc != '0) && (32'(nc) <= MAX_CHECKS) && (nv != '0) && (32'(nv) <= MAX_VARS))
    else $error("effective counts out of range");

endmodule
